@@ sv/ps2ht_pkg.sv @@
// Package for the PS/2 host byte transmitter: item and result structs, config struct,
// transmit phase enum, status codes and register indexes.
// No dependencies.
`default_nettype none

package ps2ht_pkg;

	// Configuration port geometry
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 24;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_REQUEST_LOW_TICKS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS     = 1'd1;

	// Register reset values
	localparam logic [15:0] REQUEST_LOW_TICKS_RST = 16'd100;
	localparam logic [23:0] TIMEOUT_TICKS_RST     = 24'd1000000;

	// Item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_SEND = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_BUSY    = 2'd1;
	localparam logic [1:0] ST_DONE    = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	// Frame bit positions: data bits 0..7, parity at 8, stop reached at 10
	localparam logic [3:0] DATA_BITS   = 4'd8;
	localparam logic [3:0] PARITY_SLOT = 4'd8;
	localparam logic [3:0] STOP_COUNT  = 4'd10;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_REQUEST = 3'd1,
		PH_SENDING = 3'd2,
		PH_ACK     = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] send_byte;
		logic       clk_level;
		logic       data_level;
	} in_item_t;

	typedef struct packed {
		logic       clk_drive_low;
		logic       data_drive_low;
		logic [1:0] send_status;
	} out_item_t;

	typedef struct packed {
		logic [15:0] request_low_ticks;
		logic [23:0] timeout_ticks;
	} cfg_t;

endpackage

`default_nettype wire

@@ sv/ps2ht_cfg.sv @@
// Configuration registers of the PS/2 host byte transmitter.
// Depends on ps2ht_pkg.
`default_nettype none

module ps2ht_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [ps2ht_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [ps2ht_pkg::CFG_DATA_W-1:0]    cfg_data,
	output ps2ht_pkg::cfg_t                     cfg
);
	import ps2ht_pkg::*;

	logic [15:0] request_low_ticks_q;
	logic [23:0] timeout_ticks_q;

	// Register writes, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_low_ticks_q <= REQUEST_LOW_TICKS_RST;
			timeout_ticks_q     <= TIMEOUT_TICKS_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_REQUEST_LOW_TICKS: request_low_ticks_q <= cfg_data[15:0];
				CFG_TIMEOUT_TICKS:     timeout_ticks_q     <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign cfg.request_low_ticks = request_low_ticks_q;
	assign cfg.timeout_ticks     = timeout_ticks_q;

endmodule

`default_nettype wire

@@ sv/ps2ht_core.sv @@
// Transmit state machine of the PS/2 host byte transmitter: one item per step.
// Holds the frame state and produces the result for the stepped item.
// Depends on ps2ht_pkg.
`default_nettype none

module ps2ht_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  ps2ht_pkg::in_item_t  item,
	input  ps2ht_pkg::cfg_t      cfg,
	output ps2ht_pkg::out_item_t result
);
	import ps2ht_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  shift_q, shift_d;
	logic [3:0]  bit_count_q, bit_count_d;
	logic        parity_q, parity_d;
	logic        prev_clk_q, prev_clk_d;
	logic [15:0] req_cnt_q, req_cnt_d;
	logic [23:0] budget_q, budget_d;
	logic        data_low_q, data_low_d;

	logic        active;
	logic        timed_out;
	logic        fall;
	logic        lines_high;
	logic [15:0] req_cnt_inc;
	logic [23:0] budget_inc;

	assign active      = (phase_q != PH_IDLE);
	assign timed_out   = (budget_q >= cfg.timeout_ticks);
	assign fall        = !item.clk_level && prev_clk_q;
	assign lines_high  = item.clk_level && item.data_level;
	assign req_cnt_inc = (req_cnt_q == 16'hFFFF) ? req_cnt_q : req_cnt_q + 16'd1;
	assign budget_inc  = (budget_q == 24'hFFFFFF) ? budget_q : budget_q + 24'd1;

	// Next state
	always_comb begin
		phase_d     = phase_q;
		shift_d     = shift_q;
		bit_count_d = bit_count_q;
		parity_d    = parity_q;
		prev_clk_d  = prev_clk_q;
		req_cnt_d   = req_cnt_q;
		budget_d    = budget_q;
		data_low_d  = data_low_q;
		if (item.kind == KIND_SEND) begin
			// new byte: restart the frame, dropping any transfer in flight
			shift_d     = item.send_byte;
			bit_count_d = '0;
			parity_d    = 1'b0;
			req_cnt_d   = '0;
			budget_d    = '0;
			data_low_d  = 1'b0;
			phase_d     = PH_REQUEST;
		end else if (active) begin
			if (timed_out) begin
				phase_d    = PH_IDLE;
				data_low_d = 1'b0;
			end else begin
				budget_d = budget_inc;
				case (phase_q)
					PH_REQUEST: begin
						req_cnt_d = req_cnt_inc;
						// start bit: data low, clock released
						if (req_cnt_inc >= cfg.request_low_ticks) begin
							data_low_d  = 1'b1;
							parity_d    = 1'b0;
							bit_count_d = '0;
							phase_d     = PH_SENDING;
						end
					end
					PH_SENDING: begin
						if (fall) begin
							if (bit_count_q < DATA_BITS) begin
								shift_d     = {1'b0, shift_q[7:1]};
								parity_d    = parity_q ^ shift_q[0];
								data_low_d  = !shift_q[0];
								bit_count_d = bit_count_q + 4'd1;
							end else if (bit_count_q == PARITY_SLOT) begin
								// odd parity: drive a one when the ones count is even
								data_low_d  = parity_q;
								bit_count_d = bit_count_q + 4'd1;
							end else begin
								// stop bit: release data, wait for acknowledge
								data_low_d  = 1'b0;
								bit_count_d = STOP_COUNT;
								phase_d     = PH_ACK;
							end
						end
						prev_clk_d = item.clk_level;
					end
					PH_RELEASE: begin
						if (lines_high) begin
							bit_count_d = '0;
							prev_clk_d  = 1'b1;
							phase_d     = PH_IDLE;
						end
					end
					default: ;
				endcase
				// acknowledge: device holds both lines low
				if (phase_d == PH_ACK && !item.clk_level && !item.data_level)
					phase_d = PH_RELEASE;
			end
		end else begin
			phase_d = PH_IDLE;
		end
	end

	// Outputs
	always_comb begin
		if (item.kind == KIND_SEND)
			result.send_status = ST_BUSY;
		else if (!active)
			result.send_status = ST_IDLE;
		else if (timed_out)
			result.send_status = ST_TIMEOUT;
		else if (phase_q == PH_RELEASE && lines_high)
			result.send_status = ST_DONE;
		else
			result.send_status = ST_BUSY;
		result.clk_drive_low  = (phase_d == PH_REQUEST);
		result.data_drive_low = data_low_d;
	end

	// State registers, advanced once per stepped item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			shift_q     <= '0;
			bit_count_q <= '0;
			parity_q    <= 1'b0;
			prev_clk_q  <= 1'b1;
			req_cnt_q   <= '0;
			budget_q    <= '0;
			data_low_q  <= 1'b0;
		end else if (step_en) begin
			phase_q     <= phase_d;
			shift_q     <= shift_d;
			bit_count_q <= bit_count_d;
			parity_q    <= parity_d;
			prev_clk_q  <= prev_clk_d;
			req_cnt_q   <= req_cnt_d;
			budget_q    <= budget_d;
			data_low_q  <= data_low_d;
		end
	end

	// Checks
	a_send_enters_request: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && item.kind == KIND_SEND |=> phase_q == PH_REQUEST)
		else $error("send item did not enter request phase");

	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= STOP_COUNT)
		else $error("bit count past stop position");

	a_request_data_released: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_REQUEST |-> !data_low_q)
		else $error("data driven low during request phase");

	a_end_releases_lines: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && (result.send_status == ST_DONE || result.send_status == ST_TIMEOUT)
		|-> !result.clk_drive_low && !result.data_drive_low)
		else $error("lines still driven at end of transfer");

endmodule

`default_nettype wire

@@ sv/ps2ht_byte_transmitter_top_dummy_placeholder.sv @@
// Input register and result register around the transmit state machine.
// Depends on ps2ht_pkg and ps2ht_core.
`default_nettype none

module ps2ht_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ps2ht_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ps2ht_pkg::out_item_t out_data,
	input  ps2ht_pkg::cfg_t      cfg
);
	import ps2ht_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t result_s2;
	logic      advance;
	logic      step_en;
	out_item_t result;

	// Stage 2 frees up when empty or its result is taken
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step_en  = valid_s1 && advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
	end

	ps2ht_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step_en)
			result_s2 <= result;
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	// Checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled with room in the pipeline");

	a_step_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> valid_s2)
		else $error("stepped item produced no result");

	a_result_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(result_s2))
		else $error("pending result lost or changed");

endmodule

`default_nettype wire

@@ sv/ps2_host_byte_transmitter.sv @@
// PS/2 host byte transmitter, top level.
// Depends on ps2ht_pkg, ps2ht_cfg and ps2ht_stage (which holds ps2ht_core).
//
// Host-side sender of one PS/2 byte. A send transfer loads a byte and starts the
// request (clock pulled low for request_low_ticks ticks); each tick transfer then
// carries the sampled clock and data pins and advances the frame: start bit, eight
// data bits LSB first, odd parity, stop bit, device acknowledge and line release.
// Every input transfer gives exactly one result transfer with the line drives and
// a status (idle, busy, done, timed out). One item is taken per clock cycle unless
// a stalled result holds the input, which it does only once both the input and
// the result register are full. An accepted item sits in the input register,
// passes through the combinational next-state logic and lands in the result
// register once that register is free. Configuration must be written through a
// plain write port only while no transfer is in flight; the block does not check it.
`default_nettype none

module ps2_host_byte_transmitter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  ps2ht_pkg::in_item_t               in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output ps2ht_pkg::out_item_t              out_data,
	input  logic                              cfg_write_en,
	input  logic [ps2ht_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ps2ht_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ps2ht_pkg::*;

	cfg_t cfg;

	ps2ht_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	ps2ht_stage u_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg       (cfg)
	);

endmodule

`default_nettype wire

@@ verif/ps2_host_byte_transmitter_tb.sv @@
// Self-checking testbench for ps2_host_byte_transmitter: directed table, then device frames.
// Depends on ps2ht_pkg for the item, result and register definitions; carries its own line-drive predictor.
module ps2_host_byte_transmitter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ps2ht_pkg::*;

	typedef struct packed {
		logic      on;
		out_item_t drive;
	} preset_t;

	typedef struct packed {
		in_item_t  item;
		logic      fixed;
		out_item_t want;
	} dir_row_t;

	localparam out_item_t WANT_IDLE = '{1'b0, 1'b0, ST_IDLE};
	localparam out_item_t WANT_REQ  = '{1'b1, 1'b0, ST_BUSY};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_write_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor copy of the registers and the transmit state
	logic [15:0] req_low = REQUEST_LOW_TICKS_RST;
	logic [23:0] timeout_lim = TIMEOUT_TICKS_RST;
	phase_t ph = PH_IDLE;
	logic [7:0] shreg = '0;
	logic [3:0] nbits = '0;
	logic par = 1'b0;
	logic clk_prev = 1'b1;
	logic [15:0] req_cnt = '0;
	logic [23:0] budget = '0;
	logic dat_low = 1'b0;

	out_item_t line_drive_q[$];
	preset_t preset_q[$];
	dir_row_t dir_rows[$];
	out_item_t want_r;
	out_item_t pred_r;
	preset_t preset_r;
	int mismatches = 0;
	int fed = 0;
	int send_gap_pct = 6;
	int ready_stall_pct = 60;

	ps2_host_byte_transmitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Advance the transmit state by one accepted item and return the line drives
	function automatic out_item_t next_line_drive(input in_item_t it);
		logic [1:0] st;
		out_item_t r;
		st = ST_IDLE;
		if (it.kind == KIND_SEND) begin
			shreg = it.send_byte;
			nbits = '0;
			par = 1'b0;
			req_cnt = '0;
			budget = '0;
			dat_low = 1'b0;
			ph = PH_REQUEST;
			st = ST_BUSY;
		end else if (ph != PH_IDLE) begin
			if (budget >= timeout_lim) begin
				// budget spent: let go of both lines without looking at pins
				ph = PH_IDLE;
				dat_low = 1'b0;
				st = ST_TIMEOUT;
			end else begin
				if (budget != 24'hFFFFFF)
					budget = budget + 24'd1;
				st = ST_BUSY;
				case (ph)
					PH_REQUEST: begin
						if (req_cnt != 16'hFFFF)
							req_cnt = req_cnt + 16'd1;
						if (req_cnt >= req_low) begin
							dat_low = 1'b1;
							par = 1'b0;
							nbits = '0;
							ph = PH_SENDING;
						end
					end
					PH_SENDING: begin
						if (!it.clk_level && clk_prev) begin
							if (nbits < DATA_BITS) begin
								dat_low = ~shreg[0];
								par = par ^ shreg[0];
								shreg = shreg >> 1;
								nbits = nbits + 4'd1;
							end else if (nbits == PARITY_SLOT) begin
								// odd parity: line goes low when the ones count is odd
								dat_low = par;
								nbits = nbits + 4'd1;
							end else begin
								dat_low = 1'b0;
								nbits = STOP_COUNT;
								ph = PH_ACK;
							end
						end
						clk_prev = it.clk_level;
					end
					PH_RELEASE: begin
						if (it.clk_level && it.data_level) begin
							nbits = '0;
							clk_prev = 1'b1;
							ph = PH_IDLE;
							st = ST_DONE;
						end
					end
					default: ;
				endcase
				// acknowledge is also caught on the tick that releases data for the stop bit
				if (ph == PH_ACK && !it.clk_level && !it.data_level)
					ph = PH_RELEASE;
			end
		end
		r.clk_drive_low = (ph == PH_REQUEST);
		r.data_drive_low = dat_low;
		r.send_status = st;
		return r;
	endfunction

	function automatic dir_row_t line_row(input logic kind, input logic [7:0] b, input logic c,
			input logic d, input logic fixed, input out_item_t want);
		dir_row_t r;
		r.item.kind = kind;
		r.item.send_byte = b;
		r.item.clk_level = c;
		r.item.data_level = d;
		r.fixed = fixed;
		r.want = want;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input out_item_t want, input out_item_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: want clk_low=%0b data_low=%0b status=%0d, %s",
				$realtime, what, want.clk_drive_low, want.data_drive_low, want.send_status,
				$sformatf("got clk_low=%0b data_low=%0b status=%0d",
					got.clk_drive_low, got.data_drive_low, got.send_status));
	endtask

	// Ready pattern for the result side
	always @(negedge clk)
		out_ready = ($urandom_range(0, 99) >= ready_stall_pct);

	// Result check first, then record the item accepted at this edge
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (line_drive_q.size() == 0) begin
				flag_mismatch("result with no pending transfer", WANT_IDLE, out_data);
			end else begin
				want_r = line_drive_q.pop_front();
				if (out_data.clk_drive_low !== want_r.clk_drive_low ||
						out_data.data_drive_low !== want_r.data_drive_low ||
						out_data.send_status !== want_r.send_status)
					flag_mismatch("line drive mismatch", want_r, out_data);
			end
		end
		if (arst_n && in_valid && in_ready === 1'b1) begin
			preset_r = preset_q.pop_front();
			pred_r = next_line_drive(in_data);
			line_drive_q.push_back(preset_r.on ? preset_r.drive : pred_r);
		end
	end

	// Present one item; called and returns at a falling edge
	task automatic drive_item(input in_item_t it, input logic fixed, input out_item_t want);
		preset_t p;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		p.on = fixed;
		p.drive = want;
		preset_q.push_back(p);
		in_valid = 1'b1;
		in_data = it;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		@(negedge clk);
		in_valid = 1'b0;
		fed++;
	endtask

	// Register write once every pending result is back
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		while (line_drive_q.size() != 0)
			@(negedge clk);
		cfg_write_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write_en = 1'b0;
		if (idx == CFG_REQUEST_LOW_TICKS)
			req_low = val[15:0];
		else
			timeout_lim = val;
	endtask

	// One byte send as a device would clock it: request ticks, a falling clock edge per frame bit, ack, release.
	// A broken frame is cut short and has a few pins (or kinds) flipped.
	task automatic run_frame(input bit clean);
		in_item_t seq[$];
		in_item_t it;
		int keep;
		int pick;
		it.kind = KIND_SEND;
		it.send_byte = 8'($urandom);
		it.clk_level = 1'($urandom);
		it.data_level = 1'($urandom);
		seq.push_back(it);
		it.kind = KIND_TICK;
		for (int i = 0; i < int'(req_low); i++) begin
			it.clk_level = 1'($urandom);
			it.data_level = 1'($urandom);
			seq.push_back(it);
		end
		for (int e = 0; e < 11; e++) begin
			repeat ($urandom_range(1, 2)) begin
				it.clk_level = 1'b1;
				it.data_level = 1'($urandom);
				seq.push_back(it);
			end
			repeat ($urandom_range(1, 2)) begin
				it.clk_level = 1'b0;
				it.data_level = 1'($urandom);
				seq.push_back(it);
			end
		end
		it.clk_level = 1'b1;
		it.data_level = 1'b1;
		repeat ($urandom_range(0, 2))
			seq.push_back(it);
		it.clk_level = 1'b0;
		it.data_level = 1'b0;
		repeat ($urandom_range(1, 2))
			seq.push_back(it);
		it.clk_level = 1'b1;
		it.data_level = 1'b1;
		seq.push_back(it);
		if (!clean) begin
			keep = $urandom_range(1, seq.size());
			while (seq.size() > keep)
				void'(seq.pop_back());
			repeat ($urandom_range(0, 3)) begin
				pick = $urandom_range(0, seq.size() - 1);
				seq[pick].clk_level = ~seq[pick].clk_level;
				seq[pick].data_level = 1'($urandom);
				if ($urandom_range(0, 7) == 0)
					seq[pick].kind = ~seq[pick].kind;
			end
		end
		foreach (seq[i])
			drive_item(seq[i], 1'b0, WANT_IDLE);
	endtask

	// Mostly clean frames, always closed by a clean one so the block ends idle
	task automatic run_stretch(input int n_items);
		int target;
		target = fed + n_items;
		while (fed < target)
			run_frame($urandom_range(0, 99) < 80);
		run_frame(1'b1);
	endtask

	initial begin
		in_item_t probe_it;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_write_en = 1'b0;
		cfg_index = CFG_REQUEST_LOW_TICKS;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows under the reset register values
		dir_rows.push_back(line_row(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b1, WANT_IDLE));
		dir_rows.push_back(line_row(KIND_TICK, 8'hFF, 1'b1, 1'b1, 1'b1, WANT_IDLE));
		dir_rows.push_back(line_row(KIND_SEND, 8'hFF, 1'b0, 1'b0, 1'b1, WANT_REQ));
		dir_rows.push_back(line_row(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b1, WANT_REQ));
		dir_rows.push_back(line_row(KIND_TICK, 8'hFF, 1'b1, 1'b1, 1'b1, WANT_REQ));
		// send while busy restarts with the new byte
		dir_rows.push_back(line_row(KIND_SEND, 8'h00, 1'b1, 1'b1, 1'b1, WANT_REQ));
		dir_rows.push_back(line_row(KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b1, WANT_REQ));
		dir_rows.push_back(line_row(KIND_SEND, 8'h5A, 1'b1, 1'b0, 1'b1, WANT_REQ));
		dir_rows.push_back(line_row(KIND_TICK, 8'hA5, 1'b1, 1'b0, 1'b0, WANT_IDLE));
		foreach (dir_rows[i])
			drive_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);

		// Sender idles little, receiver stalls often
		run_stretch(100);
		write_reg(CFG_REQUEST_LOW_TICKS, CFG_DATA_W'(1));
		write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'(1));
		run_stretch(30);

		// Roles swapped
		send_gap_pct = 60;
		ready_stall_pct = 6;
		write_reg(CFG_REQUEST_LOW_TICKS, CFG_DATA_W'($urandom_range(2, 6)));
		write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'($urandom_range(25, 45)));
		run_stretch(80);
		write_reg(CFG_REQUEST_LOW_TICKS, CFG_DATA_W'($urandom_range(1, 4)));
		write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'(24'hFFFFFF));
		run_stretch(80);

		// No idling: longest request cut by a short budget, then short ones
		send_gap_pct = 0;
		ready_stall_pct = 0;
		write_reg(CFG_REQUEST_LOW_TICKS, CFG_DATA_W'(16'hFFFF));
		write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'(30));
		probe_it = '0;
		probe_it.kind = KIND_SEND;
		probe_it.send_byte = 8'($urandom);
		drive_item(probe_it, 1'b0, WANT_IDLE);
		probe_it.kind = KIND_TICK;
		repeat (40) begin
			probe_it.clk_level = 1'($urandom);
			probe_it.data_level = 1'($urandom);
			drive_item(probe_it, 1'b0, WANT_IDLE);
		end
		write_reg(CFG_REQUEST_LOW_TICKS, CFG_DATA_W'($urandom_range(1, 8)));
		write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'($urandom_range(60, 200)));
		run_stretch(40);

		while (line_drive_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ files.f @@
sv/ps2ht_pkg.sv
sv/ps2ht_cfg.sv
sv/ps2ht_core.sv
sv/ps2ht_byte_transmitter_top_dummy_placeholder.sv
sv/ps2_host_byte_transmitter.sv
verif/ps2_host_byte_transmitter_tb.sv
